// ===== hdl/lmsc_pkg.sv =====
`default_nettype none

package lmsc_pkg;

  localparam int NUM_ROWS_DEF = 3;

  localparam logic [7:0] CMD_PRESENCE = 8'h01;
  localparam logic [7:0] CMD_CLEAR    = 8'h02;
  localparam logic [7:0] CMD_TOGGLE   = 8'h03;
  localparam logic [7:0] CMD_SPEED_HI = 8'h04;
  localparam logic [7:0] CMD_SPEED_LO = 8'h05;
  localparam logic [7:0] REPLY_OK     = 8'h06;
  localparam logic [7:0] REPLY_ERR    = 8'h07;

  localparam logic [7:0]  RELOAD_HIGH_RST = 8'd249;
  localparam logic [7:0]  RELOAD_LOW_RST  = 8'd255;
  localparam logic [15:0] TICK_CNT_RST    = 16'd65520;
  localparam logic [15:0] TICK_CNT_MAX    = 16'hFFFF;

  localparam logic MODE_BYTE = 1'b0;
  localparam logic MODE_TICK = 1'b1;
  localparam logic KIND_REPLY = 1'b0;
  localparam logic KIND_ROW   = 1'b1;

  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic       valid;
    logic [7:0] code;
  } lmsc_reply_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] row;
    logic [7:0] cols;
  } lmsc_row_t;

  // pair: a second copy with tlast set follows this one
  typedef struct packed {
    logic       kind;
    logic [7:0] reply_byte;
    logic [2:0] row_index;
    logic [7:0] column_bits;
    logic       pair;
  } lmsc_res_t;

endpackage

`default_nettype wire

// ===== hdl/lmsc_parser.sv =====
`default_nettype none

module lmsc_parser #(
  parameter int NUM_ROWS = lmsc_pkg::NUM_ROWS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [7:0]                rx_byte,
  output lmsc_pkg::lmsc_reply_t          reply,
  output logic [NUM_ROWS-1:0][7:0]       rows,
  output logic [7:0]                     reload_high,
  output logic [7:0]                     reload_low
);
  import lmsc_pkg::*;

  typedef enum logic [3:0] {
    PH_CMD   = 4'b0001,
    PH_ECHO  = 4'b0010,
    PH_ARG   = 4'b0100,
    PH_AECHO = 4'b1000
  } phase_t;

  phase_t                   phase_r, phase_nxt;
  logic [7:0]               cmd_r, cmd_nxt;
  logic [7:0]               arg_r, arg_nxt;
  logic [NUM_ROWS-1:0][7:0] rows_r, rows_nxt;
  logic [7:0]               hi_r, hi_nxt;
  logic [7:0]               lo_r, lo_nxt;

  // arg / 10 by reciprocal, exact for 8-bit values
  logic [15:0] prod;
  logic [4:0]  quot;
  logic [7:0]  quot_x10;
  logic [7:0]  rem;
  logic [7:0]  mask;
  logic        tog_ok;

  assign prod     = {8'd0, arg_r} * 16'd205;
  assign quot     = prod[15:11];
  assign quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem      = arg_r - quot_x10;
  assign mask     = 8'd1 << rem[2:0];
  assign tog_ok   = (quot < 5'(NUM_ROWS)) && (rem < 8'd8);

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    arg_nxt   = arg_r;
    rows_nxt  = rows_r;
    hi_nxt    = hi_r;
    lo_nxt    = lo_r;
    reply     = '0;
    case (phase_r)
      PH_CMD: begin
        if (rx_byte == CMD_CLEAR) begin
          rows_nxt = '0;
          reply    = '{valid: 1'b1, code: REPLY_OK};
        end else begin
          cmd_nxt   = rx_byte;
          phase_nxt = PH_ECHO;
        end
      end
      PH_ECHO: begin
        if (rx_byte != cmd_r) begin
          reply     = '{valid: 1'b1, code: REPLY_ERR};
          phase_nxt = PH_CMD;
        end else if (cmd_r == CMD_TOGGLE || cmd_r == CMD_SPEED_HI ||
                     cmd_r == CMD_SPEED_LO) begin
          phase_nxt = PH_ARG;
        end else begin
          reply     = '{valid: 1'b1, code: REPLY_OK};
          phase_nxt = PH_CMD;
        end
      end
      PH_ARG: begin
        arg_nxt   = rx_byte;
        phase_nxt = PH_AECHO;
      end
      PH_AECHO: begin
        phase_nxt = PH_CMD;
        if (rx_byte != arg_r) begin
          reply = '{valid: 1'b1, code: REPLY_ERR};
        end else begin
          reply = '{valid: 1'b1, code: REPLY_OK};
          case (cmd_r)
            CMD_TOGGLE: begin
              for (int i = 0; i < NUM_ROWS; i++) begin
                if (tog_ok && quot == 5'(i)) begin
                  rows_nxt[i] = rows_r[i] ^ mask;
                end
              end
            end
            CMD_SPEED_HI: hi_nxt = arg_r;
            CMD_SPEED_LO: lo_nxt = arg_r;
            default: ;
          endcase
        end
      end
      default: begin
        phase_nxt = PH_CMD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_CMD;
      cmd_r   <= '0;
      arg_r   <= '0;
      rows_r  <= '0;
      hi_r    <= RELOAD_HIGH_RST;
      lo_r    <= RELOAD_LOW_RST;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      arg_r   <= arg_nxt;
      rows_r  <= rows_nxt;
      hi_r    <= hi_nxt;
      lo_r    <= lo_nxt;
    end
  end

  assign rows        = rows_r;
  assign reload_high = hi_r;
  assign reload_low  = lo_r;

endmodule

`default_nettype wire

// ===== hdl/lmsc_scanner.sv =====
`default_nettype none

module lmsc_scanner #(
  parameter int NUM_ROWS = lmsc_pkg::NUM_ROWS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      step,
  input  wire logic [NUM_ROWS-1:0][7:0]  rows,
  input  wire logic [7:0]                reload_high,
  input  wire logic [7:0]                reload_low,
  output lmsc_pkg::lmsc_row_t            row_out
);
  import lmsc_pkg::*;

  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam logic [ROW_W:0]   NROWS_V  = (ROW_W + 1)'(NUM_ROWS);
  localparam logic [ROW_W-1:0] LAST_POS = ROW_W'(NUM_ROWS - 1);

  logic [15:0]      cnt_r, cnt_nxt;
  logic [ROW_W-1:0] pos_r, pos_nxt;
  logic [ROW_W-1:0] pos_eff;
  logic             wrap;

  assign pos_eff = ({1'b0, pos_r} < NROWS_V) ? pos_r : '0;
  assign wrap    = (cnt_r == TICK_CNT_MAX);

  always_comb begin
    row_out = '0;
    cnt_nxt = cnt_r + 16'd1;
    pos_nxt = pos_r;
    if (wrap) begin
      cnt_nxt      = {reload_high, reload_low};
      row_out.valid = 1'b1;
      row_out.row   = 3'(pos_eff);
      row_out.cols  = rows[pos_eff];
      pos_nxt       = (pos_eff == LAST_POS) ? '0 : pos_eff + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= TICK_CNT_RST;
      pos_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lmsc_out_stage.sv =====
`default_nettype none

module lmsc_out_stage (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire lmsc_pkg::lmsc_res_t  res_in,
  input  wire logic                 out_tready,
  output logic                      out_tvalid,
  output lmsc_pkg::lmsc_res_t       res_q,
  output logic                      room
);
  import lmsc_pkg::*;

  logic      valid_r;
  lmsc_res_t res_r;
  logic      take;

  assign take = valid_r && out_tready;
  assign room = !valid_r || (out_tready && !res_r.pair);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= 1'b0;
      res_r.pair <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
      res_r   <= res_in;
    end else if (take) begin
      if (res_r.pair) begin
        res_r.pair <= 1'b0;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign res_q      = res_r;

endmodule

`default_nettype wire

// ===== hdl/led_matrix_serial_command_scanner_top.sv =====
// path: an accepted input is held in the input register, then its result in the result register
// throughput: one input per cycle while the result register has room; a reply pair occupies
// the result register for both copies and holds off the next input step until its first copy is taken
// a timer tick gives one row update or nothing, a serial byte gives nothing or a pair
// reset: synchronous, active low; clears parser, rows, speed bytes, tick counter
// and scan position to their start values and empties both registers
`default_nettype none

module led_matrix_serial_command_scanner_top #(
  parameter int NUM_ROWS = lmsc_pkg::NUM_ROWS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [7:0]                        in_tdata,   // rx_byte
  input  wire logic                              in_tuser,   // mode
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [lmsc_pkg::OUT_TDATA_W-1:0]       out_tdata,  // reply_byte, row_index, column_bits
  output logic                                   out_tuser,  // kind
  output logic                                   out_tlast   // last
);
  import lmsc_pkg::*;

  logic                     in_valid_r;
  logic [7:0]               in_byte_r;
  logic                     in_mode_r;
  logic                     room;
  logic                     step;
  logic                     load;
  lmsc_reply_t              reply;
  lmsc_row_t                row_res;
  lmsc_res_t                res_new;
  lmsc_res_t                res_q;
  logic [NUM_ROWS-1:0][7:0] rows;
  logic [7:0]               reload_high;
  logic [7:0]               reload_low;

  assign step      = in_valid_r && room;
  assign in_tready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
      in_byte_r  <= in_tdata;
      in_mode_r  <= in_tuser;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  lmsc_parser #(.NUM_ROWS(NUM_ROWS)) u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step && in_mode_r == MODE_BYTE),
    .rx_byte     (in_byte_r),
    .reply       (reply),
    .rows        (rows),
    .reload_high (reload_high),
    .reload_low  (reload_low)
  );

  lmsc_scanner #(.NUM_ROWS(NUM_ROWS)) u_scanner (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step && in_mode_r == MODE_TICK),
    .rows        (rows),
    .reload_high (reload_high),
    .reload_low  (reload_low),
    .row_out     (row_res)
  );

  always_comb begin
    if (in_mode_r == MODE_TICK) begin
      res_new = '{kind: KIND_ROW, reply_byte: 8'd0, row_index: row_res.row,
                  column_bits: row_res.cols, pair: 1'b0};
      load    = step && row_res.valid;
    end else begin
      res_new = '{kind: KIND_REPLY, reply_byte: reply.code, row_index: 3'd0,
                  column_bits: 8'd0, pair: 1'b1};
      load    = step && reply.valid;
    end
  end

  lmsc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .res_in     (res_new),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .res_q      (res_q),
    .room       (room)
  );

  assign out_tdata = {5'd0, res_q.column_bits, res_q.row_index, res_q.reply_byte};
  assign out_tuser = res_q.kind;
  assign out_tlast = !res_q.pair;

endmodule

`default_nettype wire

// ===== hdl/lmsc_checker.sv =====
`default_nettype none

module lmsc_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_tready,
  input wire logic                        out_tvalid,
  input wire logic                        out_tready,
  input wire logic [lmsc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                        out_tuser,
  input wire logic                        out_tlast
);
  import lmsc_pkg::*;

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast) &&
      $stable(out_tuser))
    else $error("output changed while stalled");

  // first reply of a pair is followed at once by its closing copy
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == KIND_REPLY && !out_tlast |=>
      out_tvalid && out_tuser == KIND_REPLY && out_tlast &&
      out_tdata == $past(out_tdata))
    else $error("reply pair broken");

  // row updates are single results
  a_row_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ROW |-> out_tlast && out_tdata[7:0] == 8'd0)
    else $error("row update malformed");

  // replies carry only ok or error
  a_reply_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPLY |->
      (out_tdata[7:0] == REPLY_OK || out_tdata[7:0] == REPLY_ERR) &&
      out_tdata[OUT_TDATA_W-1:8] == '0)
    else $error("bad reply code");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("output valid after reset");

endmodule

bind led_matrix_serial_command_scanner_top lmsc_checker u_lmsc_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
  import lmsc_pkg::*;

  localparam int ROWS = NUM_ROWS_DEF;
  localparam int IDLE_LIMIT = 3000;
  localparam int RANDOM_ITEMS = 450;

  typedef struct packed {
    logic       kind;
    logic [7:0] reply;
    logic [2:0] row;
    logic [7:0] cols;
    logic       last;
  } scan_result_t;

  class scan_scoreboard;
    logic [1:0]   phase;
    logic [7:0]   cmd_q;
    logic [7:0]   arg_q;
    logic [7:0]   row_bits [ROWS];
    logic [7:0]   reload_hi;
    logic [7:0]   reload_lo;
    logic [15:0]  tick_cnt;
    logic [2:0]   scan_pos;
    scan_result_t pending_results[$];
    int           errors;
    int           replies_seen;
    int           rows_seen;

    function new();
      phase     = 2'd0;
      cmd_q     = 8'd0;
      arg_q     = 8'd0;
      foreach (row_bits[i]) row_bits[i] = 8'd0;
      reload_hi = RELOAD_HIGH_RST;
      reload_lo = RELOAD_LOW_RST;
      tick_cnt  = TICK_CNT_RST;
      scan_pos  = 3'd0;
      errors    = 0;
      replies_seen = 0;
      rows_seen = 0;
    endfunction

    task report_mismatch(string msg);
      if (errors < 40) $display("mismatch: %s", msg);
      errors++;
    endtask

    function int pending();
      return pending_results.size();
    endfunction

    function void push_reply_pair(logic [7:0] code);
      scan_result_t r;
      r = '{kind: KIND_REPLY, reply: code, row: 3'd0, cols: 8'd0, last: 1'b0};
      pending_results.push_back(r);
      r.last = 1'b1;
      pending_results.push_back(r);
    endfunction

    function bit has_argument(logic [7:0] c);
      return c == CMD_TOGGLE || c == CMD_SPEED_HI || c == CMD_SPEED_LO;
    endfunction

    function void apply_command();
      int row;
      int bitpos;
      row    = arg_q / 10;
      bitpos = arg_q % 10;
      if (cmd_q == CMD_TOGGLE) begin
        if (row < ROWS && bitpos < 8) row_bits[row][bitpos] = ~row_bits[row][bitpos];
      end else if (cmd_q == CMD_SPEED_HI) begin
        reload_hi = arg_q;
      end else if (cmd_q == CMD_SPEED_LO) begin
        reload_lo = arg_q;
      end
    endfunction

    function void parse_byte(logic [7:0] b);
      case (phase)
        2'd0: begin
          if (b == CMD_CLEAR) begin
            foreach (row_bits[i]) row_bits[i] = 8'd0;
            push_reply_pair(REPLY_OK);
          end else begin
            cmd_q = b;
            phase = 2'd1;
          end
        end
        2'd1: begin
          if (b != cmd_q) begin
            phase = 2'd0;
            push_reply_pair(REPLY_ERR);
          end else if (has_argument(cmd_q)) begin
            phase = 2'd2;
          end else begin
            phase = 2'd0;
            push_reply_pair(REPLY_OK);
          end
        end
        2'd2: begin
          arg_q = b;
          phase = 2'd3;
        end
        default: begin
          phase = 2'd0;
          if (b != arg_q) begin
            push_reply_pair(REPLY_ERR);
          end else begin
            apply_command();
            push_reply_pair(REPLY_OK);
          end
        end
      endcase
    endfunction

    function void timer_tick();
      scan_result_t r;
      int pos;
      if (tick_cnt != TICK_CNT_MAX) begin
        tick_cnt = tick_cnt + 16'd1;
      end else begin
        tick_cnt = {reload_hi, reload_lo};
        pos = (scan_pos >= ROWS) ? 0 : scan_pos;
        r = '{kind: KIND_ROW, reply: 8'd0, row: pos[2:0], cols: row_bits[pos], last: 1'b1};
        pending_results.push_back(r);
        pos++;
        if (pos >= ROWS) pos = 0;
        scan_pos = pos[2:0];
      end
    endfunction

    function void note_input(logic mode, logic [7:0] b);
      if (mode == MODE_TICK) timer_tick();
      else parse_byte(b);
    endfunction

    task check_result(scan_result_t got);
      scan_result_t want;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d data=%h/%0d/%h last=%0d",
                                  got.kind, got.reply, got.row, got.cols, got.last));
        return;
      end
      want = pending_results.pop_front();
      if (got.kind == KIND_ROW) rows_seen++;
      else replies_seen++;
      if (got.kind != want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.reply != want.reply)
        report_mismatch($sformatf("reply_byte %h, expected %h", got.reply, want.reply));
      if (got.row != want.row)
        report_mismatch($sformatf("row_index %0d, expected %0d", got.row, want.row));
      if (got.cols != want.cols)
        report_mismatch($sformatf("column_bits %h, expected %h", got.cols, want.cols));
      if (got.last != want.last)
        report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  scan_scoreboard sb = new();
  int burst_left = 0;
  int n_items = 0;
  int idle_cycles = 0;

  led_matrix_serial_command_scanner_top #(.NUM_ROWS(ROWS)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver stall pattern: stretches of always ready, coin flip, or mostly stalled
  initial begin
    int style;
    int len;
    out_tready = 1'b0;
    forever begin
      style = $urandom_range(0, 2);
      len   = $urandom_range(10, 60);
      repeat (len) begin
        @(negedge clk);
        case (style)
          0: out_tready = 1'b1;
          1: out_tready = 1'($urandom_range(0, 1));
          default: out_tready = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{kind: out_tuser, reply: out_tdata[7:0], row: out_tdata[10:8],
                        cols: out_tdata[18:11], last: out_tlast});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(logic mode, logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(mode, b);
    n_items++;
    burst_left--;
    @(negedge clk);
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
  endtask

  // bring the parser back to waiting for a command without side effects
  task automatic resync();
    while (sb.phase != 2'd0)
      send_item(MODE_BYTE, (sb.phase == 2'd3) ? ~sb.arg_q : CMD_CLEAR);
  endtask

  task automatic send_frame(logic [7:0] c, logic [7:0] a, bit echo_bad, bit arg_bad);
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    send_item(MODE_BYTE, c);
    if (c == CMD_CLEAR) return;
    maybe_ticks();
    send_item(MODE_BYTE, echo_bad ? (c ^ flip) : c);
    if (echo_bad || !(c == CMD_TOGGLE || c == CMD_SPEED_HI || c == CMD_SPEED_LO)) return;
    maybe_ticks();
    send_item(MODE_BYTE, a);
    maybe_ticks();
    send_item(MODE_BYTE, arg_bad ? (a ^ flip) : a);
  endtask

  task automatic drain(int extra);
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  initial begin
    int pick;
    int next_drain;
    logic [7:0] c;
    logic [7:0] a;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tuser  = MODE_BYTE;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // directed: clear, presence, bad echo, both speeds at max, toggles in and out of range
    send_frame(CMD_CLEAR, 8'd0, 1'b0, 1'b0);
    send_frame(CMD_PRESENCE, 8'd0, 1'b0, 1'b0);
    send_item(MODE_BYTE, 8'h00);
    send_item(MODE_BYTE, 8'h01);
    send_frame(CMD_SPEED_HI, 8'hFF, 1'b0, 1'b0);
    send_frame(CMD_SPEED_LO, 8'hFF, 1'b0, 1'b0);
    send_frame(CMD_TOGGLE, 8'd0, 1'b0, 1'b0);
    send_frame(CMD_TOGGLE, 8'd27, 1'b0, 1'b0);
    send_frame(CMD_TOGGLE, 8'hFF, 1'b0, 1'b0);
    drain(4);

    next_drain = n_items + 150;
    while (n_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        repeat ($urandom_range(1, 10)) send_item(MODE_TICK, 8'($urandom_range(0, 255)));
      end else if (pick < 48) begin
        resync();
        send_frame(CMD_CLEAR, 8'd0, 1'b0, 1'b0);
      end else if (pick < 70) begin
        resync();
        a = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 29)) :
                                          8'($urandom_range(0, 255));
        send_frame(CMD_TOGGLE, a, 1'b0, 1'b0);
      end else if (pick < 78) begin
        resync();
        a = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(8'hF0, 8'hFF)) :
                                         8'($urandom_range(0, 255));
        send_frame(CMD_SPEED_LO, a, 1'b0, 1'b0);
      end else if (pick < 84) begin
        resync();
        send_frame(CMD_SPEED_HI, ($urandom_range(0, 6) != 0) ? 8'hFF : 8'hFE, 1'b0, 1'b0);
      end else if (pick < 87) begin
        // any high speed byte, then restored to the maximum
        resync();
        send_item(MODE_BYTE, CMD_SPEED_HI);
        send_item(MODE_BYTE, CMD_SPEED_HI);
        a = 8'($urandom_range(0, 255));
        send_item(MODE_BYTE, a);
        send_item(MODE_BYTE, a);
        send_frame(CMD_SPEED_HI, 8'hFF, 1'b0, 1'b0);
      end else if (pick < 92) begin
        resync();
        c = 8'($urandom_range(0, 255));
        if (c == CMD_TOGGLE || c == CMD_SPEED_HI || c == CMD_SPEED_LO) c = CMD_PRESENCE;
        send_frame(c, 8'd0, 1'b0, 1'b0);
      end else if (pick < 96) begin
        resync();
        c = CMD_TOGGLE + 8'($urandom_range(0, 2));
        a = (c == CMD_TOGGLE) ? 8'($urandom_range(0, 255)) : 8'hFF;
        if ($urandom_range(0, 1)) send_frame(c, a, 1'b1, 1'b0);
        else send_frame(c, a, 1'b0, 1'b1);
      end else begin
        repeat ($urandom_range(1, 3)) send_item(MODE_BYTE, 8'($urandom_range(0, 255)));
        resync();
      end
      if (n_items >= next_drain) begin
        drain(4);
        next_drain = n_items + 150;
      end
    end

    drain(8);
    if (sb.pending() != 0) sb.report_mismatch("results still expected at end of run");
    $display("run covered %0d input transactions: %0d reply and %0d row results checked",
             n_items, sb.replies_seen, sb.rows_seen);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
